// ----- design/kqt_pkg.sv -----
// Shared constants for the keyed quantity table: widths, command codes and status codes.
`default_nettype none

package kqt_pkg;

  // Width of a key and of a quantity.
  localparam int DATA_W = 32;

  localparam int CMD_W    = 2;
  localparam int STATUS_W = 2;
  localparam int IDX_W    = 7;
  localparam int FILL_W   = 8;

  localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
  localparam logic [CMD_W-1:0] CMD_SEARCH = 2'd1;
  localparam logic [CMD_W-1:0] CMD_UPDATE = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL = 2'd1;
  localparam logic [STATUS_W-1:0] ST_DUP  = 2'd2;
  localparam logic [STATUS_W-1:0] ST_MISS = 2'd3;

  localparam logic signed [DATA_W-1:0] QTY_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [DATA_W-1:0] QTY_MIN = 32'sh8000_0000;

endpackage : kqt_pkg

`default_nettype wire

// ----- design/kqt_store.sv -----
// Key and quantity memories with one registered read port and a shared write address.
`default_nettype none

module kqt_store
  import kqt_pkg::*;
#(
  parameter int TABLE_DEPTH = 128,
  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1
) (
  input  wire logic                     clk,
  input  wire logic [AW-1:0]            rd_addr,
  output logic signed [DATA_W-1:0]      key_q,
  output logic signed [DATA_W-1:0]      qty_q,
  input  wire logic                     key_we,
  input  wire logic                     qty_we,
  input  wire logic [AW-1:0]            wr_addr,
  input  wire logic signed [DATA_W-1:0] wr_key,
  input  wire logic signed [DATA_W-1:0] wr_qty
);

  logic signed [DATA_W-1:0] key_mem [TABLE_DEPTH];
  logic signed [DATA_W-1:0] qty_mem [TABLE_DEPTH];

  // Both arrays are read at the same address so a key and its quantity arrive together.
  always_ff @(posedge clk) begin
    if (key_we) begin
      key_mem[wr_addr] <= wr_key;
    end
    key_q <= key_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (qty_we) begin
      qty_mem[wr_addr] <= wr_qty;
    end
    qty_q <= qty_mem[rd_addr];
  end

endmodule : kqt_store

`default_nettype wire

// ----- design/keyed_quantity_table.sv -----
// Top level of the keyed quantity table: command sequencer, linear key scan and result register.
`default_nettype none

// Channel   Dir  Beat contents (lowest bits first)
// --------  ---  ----------------------------------------------------------
// in_*      in   tuser: cmd[1:0]; tdata: key[31:0], amount[63:32]
// out_*     out  tuser: status[1:0]; tdata: entry_index[6:0],
//                quantity[38:7], fill_count[46:39], zero pad [47]
//
// One command is handled at a time. A search, update or insert walks the
// filled entries from index 0 upward through the single read port of the
// store, one entry per cycle, and stops at the first matching key; an
// insert into a full table or an unknown command skips the scan. rst_n
// empties the table (the fill count returns to zero); the memories
// themselves are never cleared. The input side is ready only while no
// command is in work, and a result that is not taken holds the sequencer
// until out_tready rises.

module keyed_quantity_table
  import kqt_pkg::*;
#(
  parameter int TABLE_DEPTH = 128
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [63:0] in_tdata,   // key[31:0], amount[63:32]
  input  wire logic [1:0]  in_tuser,   // cmd[1:0]
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [47:0]      out_tdata,  // entry_index[6:0], quantity[38:7], fill_count[46:39]
  output logic [1:0]       out_tuser   // status[1:0]
);

  // Address width for the stores and count width able to hold TABLE_DEPTH itself.
  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_UPD  = 2'd2;
  localparam logic [1:0] S_RESP = 2'd3;

  logic [1:0]               state_r, state_nxt;
  logic [CMD_W-1:0]         cmd_r, cmd_nxt;
  logic signed [DATA_W-1:0] key_r, key_nxt;
  logic signed [DATA_W-1:0] amt_r, amt_nxt;
  logic [CW-1:0]            count_r, count_nxt;
  logic [CW-1:0]            scan_r, scan_nxt;
  logic                     chk_vld_r, chk_vld_nxt;
  logic [AW-1:0]            chk_idx_r, chk_idx_nxt;
  logic signed [DATA_W-1:0] hit_qty_r, hit_qty_nxt;
  logic [AW-1:0]            hit_idx_r, hit_idx_nxt;
  logic [STATUS_W-1:0]      res_status_r, res_status_nxt;
  logic [AW-1:0]            res_idx_r, res_idx_nxt;
  logic signed [DATA_W-1:0] res_qty_r, res_qty_nxt;
  logic                     out_tvalid_r, out_tvalid_nxt;
  logic [47:0]              out_tdata_r, out_tdata_nxt;
  logic [1:0]               out_tuser_r, out_tuser_nxt;

  logic [AW-1:0]            rd_addr;
  logic signed [DATA_W-1:0] key_q;
  logic signed [DATA_W-1:0] qty_q;
  logic                     key_we;
  logic                     qty_we;
  logic [AW-1:0]            wr_addr;
  logic signed [DATA_W-1:0] wr_qty;

  logic                     hit;
  logic                     scan_end;
  logic                     table_full;
  logic signed [DATA_W:0]   sum;
  logic signed [DATA_W-1:0] sum_sat;
  logic [AW+IDX_W-1:0]      idx_ext;
  logic [CW+FILL_W-1:0]     fill_ext;

  kqt_store #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_store (
    .clk     (clk),
    .rd_addr (rd_addr),
    .key_q   (key_q),
    .qty_q   (qty_q),
    .key_we  (key_we),
    .qty_we  (qty_we),
    .wr_addr (wr_addr),
    .wr_key  (key_r),
    .wr_qty  (wr_qty)
  );

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

  // The entry read last cycle is on key_q now; it matches when it was a real read.
  assign hit        = chk_vld_r && (key_q == key_r);
  // Every filled entry has been issued and checked without a match.
  assign scan_end   = !chk_vld_r && (scan_r >= count_r);
  assign table_full = (count_r >= CW'(TABLE_DEPTH));

  // Saturating add for the update command, one bit wider to see overflow.
  assign sum = {hit_qty_r[DATA_W-1], hit_qty_r} + {amt_r[DATA_W-1], amt_r};
  always_comb begin
    if (sum[DATA_W] != sum[DATA_W-1]) begin
      sum_sat = sum[DATA_W] ? QTY_MIN : QTY_MAX;
    end else begin
      sum_sat = sum[DATA_W-1:0];
    end
  end

  // Result fields carry only the low bits of the index and of the count.
  assign idx_ext  = {{IDX_W{1'b0}}, res_idx_r};
  assign fill_ext = {{FILL_W{1'b0}}, count_r};

  always_comb begin
    state_nxt      = state_r;
    cmd_nxt        = cmd_r;
    key_nxt        = key_r;
    amt_nxt        = amt_r;
    count_nxt      = count_r;
    scan_nxt       = scan_r;
    chk_vld_nxt    = 1'b0;
    chk_idx_nxt    = chk_idx_r;
    hit_qty_nxt    = hit_qty_r;
    hit_idx_nxt    = hit_idx_r;
    res_status_nxt = res_status_r;
    res_idx_nxt    = res_idx_r;
    res_qty_nxt    = res_qty_r;
    out_tvalid_nxt = out_tvalid_r && !out_tready;
    out_tdata_nxt  = out_tdata_r;
    out_tuser_nxt  = out_tuser_r;
    rd_addr        = scan_r[AW-1:0];
    key_we         = 1'b0;
    qty_we         = 1'b0;
    wr_addr        = count_r[AW-1:0];
    wr_qty         = amt_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd_nxt        = in_tuser;
          key_nxt        = in_tdata[31:0];
          amt_nxt        = in_tdata[63:32];
          scan_nxt       = '0;
          res_idx_nxt    = '0;
          res_qty_nxt    = '0;
          if (in_tuser == CMD_INSERT && table_full) begin
            res_status_nxt = ST_FULL;
            state_nxt      = S_RESP;
          end else if (in_tuser != CMD_INSERT && in_tuser != CMD_SEARCH &&
                       in_tuser != CMD_UPDATE) begin
            res_status_nxt = ST_MISS;
            state_nxt      = S_RESP;
          end else begin
            state_nxt = S_SCAN;
          end
        end
      end

      S_SCAN: begin
        if (hit) begin
          if (cmd_r == CMD_INSERT) begin
            res_status_nxt = ST_DUP;
            state_nxt      = S_RESP;
          end else if (cmd_r == CMD_SEARCH) begin
            res_status_nxt = ST_OK;
            res_idx_nxt    = chk_idx_r;
            res_qty_nxt    = qty_q;
            state_nxt      = S_RESP;
          end else begin
            hit_qty_nxt = qty_q;
            hit_idx_nxt = chk_idx_r;
            state_nxt   = S_UPD;
          end
        end else if (scan_end) begin
          if (cmd_r == CMD_INSERT) begin
            // Append at the first free entry.
            key_we         = 1'b1;
            qty_we         = 1'b1;
            count_nxt      = count_r + CW'(1);
            res_status_nxt = ST_OK;
            res_idx_nxt    = count_r[AW-1:0];
            res_qty_nxt    = amt_r;
          end else begin
            res_status_nxt = ST_MISS;
          end
          state_nxt = S_RESP;
        end else if (scan_r < count_r) begin
          // Issue the next entry; its key is compared in the following cycle.
          chk_vld_nxt = 1'b1;
          chk_idx_nxt = scan_r[AW-1:0];
          scan_nxt    = scan_r + CW'(1);
        end
      end

      S_UPD: begin
        qty_we         = 1'b1;
        wr_addr        = hit_idx_r;
        wr_qty         = sum_sat;
        res_status_nxt = ST_OK;
        res_idx_nxt    = hit_idx_r;
        res_qty_nxt    = sum_sat;
        state_nxt      = S_RESP;
      end

      S_RESP: begin
        if (!out_tvalid_r || out_tready) begin
          out_tvalid_nxt = 1'b1;
          out_tuser_nxt  = res_status_r;
          out_tdata_nxt  = {1'b0, fill_ext[FILL_W-1:0], res_qty_r, idx_ext[IDX_W-1:0]};
          state_nxt      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      count_r      <= '0;
      chk_vld_r    <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      count_r      <= count_nxt;
      chk_vld_r    <= chk_vld_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  // Payload and working registers need no reset.
  always_ff @(posedge clk) begin
    cmd_r        <= cmd_nxt;
    key_r        <= key_nxt;
    amt_r        <= amt_nxt;
    scan_r       <= scan_nxt;
    chk_idx_r    <= chk_idx_nxt;
    hit_qty_r    <= hit_qty_nxt;
    hit_idx_r    <= hit_idx_nxt;
    res_status_r <= res_status_nxt;
    res_idx_r    <= res_idx_nxt;
    res_qty_r    <= res_qty_nxt;
    out_tdata_r  <= out_tdata_nxt;
    out_tuser_r  <= out_tuser_nxt;
  end

endmodule : keyed_quantity_table

`default_nettype wire
